[rtl/oorm_pkg.sv]
// Shared types and constants for the out-of-range mode finder.
package oorm_pkg;

    localparam int ID_W      = 16;
    localparam int READ_W    = 16;
    localparam int COUNT_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int DEPTH_DEF = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_IDX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IDX = 2'd1;

    localparam logic signed [READ_W-1:0] MIN_RESET = 16'sh8000;
    localparam logic signed [READ_W-1:0] MAX_RESET = 16'sh7FFF;

    typedef struct packed {
        logic [ID_W-1:0]          sensor_id;
        logic signed [READ_W-1:0] reading;
        logic                     last_of_set;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]    worst_id;
        logic [COUNT_W-1:0] worst_count;
        logic               found;
        logic               table_full;
    } out_item_t;

    // One slot of the id table
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [COUNT_W-1:0] count;
    } slot_entry_t;

endpackage

[rtl/oorm_slot_mem.sv]
// Id/count table: single write port, single registered read port.
module oorm_slot_mem
    import oorm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output slot_entry_t   rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  slot_entry_t   wr_data
);

    slot_entry_t mem [DEPTH];
    slot_entry_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/out_of_range_mode_finder.sv]
// Top level: limit check, sequential id-table search and mode tracking.
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   in_item_t  (sensor_id, reading, last_of_set)
//  out      output     out_valid / out_stall out_item_t (worst_id, worst_count, found, ...)
//  cfg      input      cfg_we                cfg_index, cfg_wdata (min_value, max_value)
//
// An in-range reading goes straight to the finish step. A faulty reading is looked up
// among the used slots (used = number of ids held); the search reads one table slot per
// cycle through the single read port and checks it on one shared id comparator.
// in_stall is high whenever the sequencer is busy; a result waits in the output
// register and only a last-of-set transaction stalls behind an untaken result.
// Reset (rst_n, async low) empties the table and sets the limits to full scale.
module out_of_range_mode_finder
    import oorm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int UW = AW + 1;
    localparam logic [UW-1:0] DEPTH_U = UW'(TABLE_DEPTH);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic signed [READ_W-1:0] min_reg, max_reg;
    logic [ID_W-1:0]          id_reg, id_next;
    logic                     last_reg, last_next;
    logic [UW-1:0]            idx_reg, idx_next;
    logic [AW-1:0]            cmp_reg, cmp_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic [AW-1:0]            slot_reg, slot_next;
    logic [COUNT_W-1:0]       cnt_reg, cnt_next;
    logic [UW-1:0]            used_reg, used_next;
    logic [AW-1:0]            best_slot_reg, best_slot_next;
    logic [COUNT_W-1:0]       best_count_reg, best_count_next;
    logic [ID_W-1:0]          best_id_reg, best_id_next;
    logic                     ovf_reg, ovf_next;
    logic                     out_valid_reg, out_valid_next;
    out_item_t                out_data_reg, out_data_next;

    logic                     in_fire;
    logic                     fault;
    logic                     hit;
    logic [COUNT_W-1:0]       cnt_inc;
    logic                     mem_rd_en;
    logic                     mem_wr_en;
    slot_entry_t              mem_rd_data;
    slot_entry_t              mem_wr_data;

    oorm_slot_mem #(
        .DEPTH (TABLE_DEPTH)
    ) u_slot_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (slot_reg),
        .wr_data (mem_wr_data)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // limit check on the incoming reading
    assign fault = ($signed(in_data.reading) > max_reg) || ($signed(in_data.reading) < min_reg);

    // shared id comparator on the slot just read
    assign hit = rd_vld_reg && (mem_rd_data.id == id_reg);

    // saturating increment
    assign cnt_inc = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + COUNT_W'(1);

    assign mem_wr_en         = (state_reg == S_UPDATE);
    assign mem_wr_data.id    = id_reg;
    assign mem_wr_data.count = cnt_inc;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        id_next         = id_reg;
        last_next       = last_reg;
        idx_next        = idx_reg;
        cmp_next        = cmp_reg;
        rd_vld_next     = 1'b0;
        slot_next       = slot_reg;
        cnt_next        = cnt_reg;
        used_next       = used_reg;
        best_slot_next  = best_slot_reg;
        best_count_next = best_count_reg;
        best_id_next    = best_id_reg;
        ovf_next        = ovf_reg;
        mem_rd_en       = 1'b0;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    id_next   = in_data.sensor_id;
                    last_next = in_data.last_of_set;
                    idx_next  = '0;
                    state_next = fault ? S_SEARCH : S_FINISH;
                end
            end

            S_SEARCH:
            begin
                if (hit)
                begin
                    slot_next  = cmp_reg;
                    cnt_next   = mem_rd_data.count;
                    state_next = S_UPDATE;
                end
                else if (idx_reg < used_reg)
                begin
                    mem_rd_en   = 1'b1;
                    rd_vld_next = 1'b1;
                    cmp_next    = idx_reg[AW-1:0];
                    idx_next    = idx_reg + UW'(1);
                end
                else if (!rd_vld_reg)
                begin
                    // id not in the table
                    if (used_reg >= DEPTH_U)
                    begin
                        ovf_next   = 1'b1;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        slot_next  = used_reg[AW-1:0];
                        cnt_next   = '0;
                        used_next  = used_reg + UW'(1);
                        state_next = S_UPDATE;
                    end
                end
            end

            S_UPDATE:
            begin
                if ((cnt_inc > best_count_reg) ||
                    ((cnt_inc == best_count_reg) && (slot_reg < best_slot_reg)))
                begin
                    best_count_next = cnt_inc;
                    best_slot_next  = slot_reg;
                    best_id_next    = id_reg;
                end
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.found       = (best_count_reg != '0);
                    out_data_next.worst_id    = (best_count_reg != '0) ? best_id_reg : '0;
                    out_data_next.worst_count = best_count_reg;
                    out_data_next.table_full  = ovf_reg;
                    used_next       = '0;
                    best_slot_next  = '0;
                    best_count_next = '0;
                    ovf_next        = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rd_vld_reg     <= 1'b0;
            used_reg       <= '0;
            best_slot_reg  <= '0;
            best_count_reg <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            min_reg        <= MIN_RESET;
            max_reg        <= MAX_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            rd_vld_reg     <= rd_vld_next;
            used_reg       <= used_next;
            best_slot_reg  <= best_slot_next;
            best_count_reg <= best_count_next;
            ovf_reg        <= ovf_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we && (cfg_index == CFG_MIN_IDX))
            begin
                min_reg <= $signed(cfg_wdata);
            end
            if (cfg_we && (cfg_index == CFG_MAX_IDX))
            begin
                max_reg <= $signed(cfg_wdata);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        last_reg     <= last_next;
        idx_reg      <= idx_next;
        cmp_reg      <= cmp_next;
        slot_reg     <= slot_next;
        cnt_reg      <= cnt_next;
        best_id_reg  <= best_id_next;
        out_data_reg <= out_data_next;
    end

    // checks
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= DEPTH_U)
        else $error("slot fill count beyond table depth");

    a_best_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (best_count_reg != '0) |-> (UW'(best_slot_reg) < used_reg))
        else $error("best slot outside the used part of the table");

    a_found_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.found == (out_data_reg.worst_count != '0)))
        else $error("found flag disagrees with worst count");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != S_IDLE))
        else $error("sequencer idle right after a transaction");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside the finish step");

endmodule
